// ===== src/nfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfbp_pkg
// Shared types and constants of the next-fit block pool allocator.
// ----------------------------------------------------------------------------
package nfbp_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 1024;
  localparam int SLOT_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int BYTES_W    = 17;
  localparam int BYTES_MAX  = 65536;
  localparam int BASE_W     = 32;
  localparam int ADDR_W     = 33;
  localparam int PROD_W     = CNT_W + BYTES_W;
  localparam int DIV_W      = BYTES_W + SLOT_W - 1;
  localparam int STEP_W     = $clog2(SLOT_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT = 2'd0,
    CFG_BLOCK_BYTES = 2'd1,
    CFG_POOL_BASE   = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_GET_BEG,
    S_GET_CHK,
    S_GET_MUL,
    S_GET_ADD,
    S_PUT_LIM,
    S_PUT_CMP,
    S_PUT_DIV,
    S_PUT_CHK,
    S_PUT_UPD,
    S_OUT
  } state_e;

  // Used map access
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wdata;
  } map_req_t;

  // Effective configuration
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
    logic [BASE_W-1:0]  base;
  } core_cfg_t;

  // Finished result
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
  } core_res_t;

endpackage

// ===== src/nfbp_used_map.sv =====
// ----------------------------------------------------------------------------
// nfbp_used_map
// One bit per slot used map, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nfbp_used_map (
  input  logic              clk_i,
  input  nfbp_pkg::map_req_t req_i,
  output logic              rdata_o
);

  logic mem [nfbp_pkg::MAX_BLOCKS];
  logic rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/nfbp_core.sv =====
// ----------------------------------------------------------------------------
// nfbp_core
// Sequencer with a shared multiplier and a restoring divide step: next-fit
// scan for get, boundary check and slot lookup for put.
// ----------------------------------------------------------------------------
module nfbp_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nfbp_pkg::core_cfg_t                  cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [nfbp_pkg::ADDR_W-1:0]          chunk_address_i,
  input  logic                                 out_free_i,
  output nfbp_pkg::core_res_t                  res_o,
  output nfbp_pkg::map_req_t                   map_req_o,
  input  logic                                 map_rdata_i
);

  localparam int SLOT_W = nfbp_pkg::SLOT_W;
  localparam int CNT_W  = nfbp_pkg::CNT_W;
  localparam int ADDR_W = nfbp_pkg::ADDR_W;
  localparam int PROD_W = nfbp_pkg::PROD_W;
  localparam int DIV_W  = nfbp_pkg::DIV_W;
  localparam int STEP_W = nfbp_pkg::STEP_W;

  nfbp_pkg::state_e state_q, state_d;

  // control state
  logic [SLOT_W-1:0] clr_q;
  logic [CNT_W-1:0]  used_total_q;
  logic [CNT_W-1:0]  next_q;

  // payload
  logic [SLOT_W-1:0] ptr_q, chk_q, k_q, quo_q;
  logic [ADDR_W-1:0] rem_q, addr_q;
  logic [DIV_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic              miss_q;
  logic [PROD_W-1:0] prod_q;
  nfbp_pkg::status_e res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [ADDR_W-1:0] res_addr_q;

  logic              accept;
  logic              get_full, get_free, get_last, put_miss, borrow;
  logic [SLOT_W-1:0] start;
  logic [ADDR_W:0]   trial;
  logic [CNT_W-1:0]  mul_a;

  // increment a slot with wrap at the block count
  function automatic logic [SLOT_W-1:0] wrap_inc(logic [SLOT_W-1:0] s,
                                                 logic [CNT_W-1:0]  cnt);
    logic [CNT_W-1:0] n;
    n = {1'b0, s} + CNT_W'(1);
    return (n >= cnt) ? '0 : n[SLOT_W-1:0];
  endfunction

  // decisions
  assign accept   = in_valid_i && (state_q == nfbp_pkg::S_IDLE);
  assign get_full = used_total_q >= cfg_i.count;
  assign start    = (next_q >= cfg_i.count) ? '0 : next_q[SLOT_W-1:0];
  assign get_free = !map_rdata_i;
  assign get_last = {1'b0, k_q} == (cfg_i.count - CNT_W'(1));
  assign put_miss = miss_q || (rem_q >= ADDR_W'(prod_q));
  assign trial    = {1'b0, rem_q} - {1'b0, ADDR_W'(div_q)};
  assign borrow   = trial[ADDR_W];

  // shared multiplier: count * bytes for the put limit, slot * bytes for get
  assign mul_a = (state_q == nfbp_pkg::S_GET_MUL) ? {1'b0, res_slot_q} : cfg_i.count;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * PROD_W'(cfg_i.bytes);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfbp_pkg::S_CLEAR: begin
        if (clr_q == SLOT_W'(nfbp_pkg::MAX_BLOCKS - 1)) state_d = nfbp_pkg::S_IDLE;
      end
      nfbp_pkg::S_IDLE: begin
        if (in_valid_i) state_d = func_i ? nfbp_pkg::S_PUT_LIM : nfbp_pkg::S_GET_BEG;
      end
      nfbp_pkg::S_GET_BEG: state_d = get_full ? nfbp_pkg::S_OUT : nfbp_pkg::S_GET_CHK;
      nfbp_pkg::S_GET_CHK: begin
        if (get_free) state_d = nfbp_pkg::S_GET_MUL;
        else if (get_last) state_d = nfbp_pkg::S_OUT;
      end
      nfbp_pkg::S_GET_MUL: state_d = nfbp_pkg::S_GET_ADD;
      nfbp_pkg::S_GET_ADD: state_d = nfbp_pkg::S_OUT;
      nfbp_pkg::S_PUT_LIM: state_d = nfbp_pkg::S_PUT_CMP;
      nfbp_pkg::S_PUT_CMP: state_d = put_miss ? nfbp_pkg::S_OUT : nfbp_pkg::S_PUT_DIV;
      nfbp_pkg::S_PUT_DIV: begin
        if (step_q == '0) state_d = nfbp_pkg::S_PUT_CHK;
      end
      nfbp_pkg::S_PUT_CHK: begin
        state_d = (rem_q != '0) ? nfbp_pkg::S_OUT : nfbp_pkg::S_PUT_UPD;
      end
      nfbp_pkg::S_PUT_UPD: state_d = nfbp_pkg::S_OUT;
      nfbp_pkg::S_OUT: begin
        if (out_free_i) state_d = nfbp_pkg::S_IDLE;
      end
      default: state_d = nfbp_pkg::S_IDLE;
    endcase
  end

  // outputs: map accesses and result handoff
  always_comb begin
    map_req_o = '0;
    res_o     = '0;
    unique case (state_q)
      nfbp_pkg::S_CLEAR: begin
        map_req_o.wr_en   = 1'b1;
        map_req_o.wr_addr = clr_q;
      end
      nfbp_pkg::S_GET_BEG: begin
        map_req_o.rd_en   = !get_full;
        map_req_o.rd_addr = start;
      end
      nfbp_pkg::S_GET_CHK: begin
        // fetch the next slot while the current one is checked
        map_req_o.rd_en   = 1'b1;
        map_req_o.rd_addr = ptr_q;
        map_req_o.wr_en   = get_free;
        map_req_o.wr_addr = chk_q;
        map_req_o.wdata   = 1'b1;
      end
      nfbp_pkg::S_PUT_CHK: begin
        map_req_o.rd_en   = (rem_q == '0);
        map_req_o.rd_addr = quo_q;
      end
      nfbp_pkg::S_PUT_UPD: begin
        map_req_o.wr_en   = map_rdata_i;
        map_req_o.wr_addr = quo_q;
      end
      nfbp_pkg::S_OUT: begin
        res_o.valid  = out_free_i;
        res_o.status = res_status_q;
        res_o.slot   = res_slot_q;
        res_o.addr   = res_addr_q;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != nfbp_pkg::S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nfbp_pkg::S_CLEAR;
      clr_q        <= '0;
      used_total_q <= '0;
      next_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == nfbp_pkg::S_CLEAR) clr_q <= clr_q + SLOT_W'(1);
      if (state_q == nfbp_pkg::S_GET_CHK && get_free) begin
        used_total_q <= used_total_q + CNT_W'(1);
        next_q       <= {1'b0, chk_q} + CNT_W'(1);
      end
      if (state_q == nfbp_pkg::S_PUT_UPD && map_rdata_i && used_total_q != '0) begin
        used_total_q <= used_total_q - CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      nfbp_pkg::S_IDLE: begin
        if (accept) begin
          addr_q <= chunk_address_i;
          miss_q <= chunk_address_i < {1'b0, cfg_i.base};
          rem_q  <= chunk_address_i - {1'b0, cfg_i.base};
        end
      end
      nfbp_pkg::S_GET_BEG: begin
        res_status_q <= nfbp_pkg::ST_FULL;
        res_slot_q   <= '0;
        res_addr_q   <= '0;
        chk_q        <= start;
        ptr_q        <= wrap_inc(start, cfg_i.count);
        k_q          <= '0;
      end
      nfbp_pkg::S_GET_CHK: begin
        if (get_free) begin
          res_status_q <= nfbp_pkg::ST_OK;
          res_slot_q   <= chk_q;
        end else begin
          chk_q <= ptr_q;
          ptr_q <= wrap_inc(ptr_q, cfg_i.count);
          k_q   <= k_q + SLOT_W'(1);
        end
      end
      nfbp_pkg::S_GET_ADD: begin
        res_addr_q <= {1'b0, cfg_i.base} + ADDR_W'(prod_q);
      end
      nfbp_pkg::S_PUT_CMP: begin
        res_status_q <= nfbp_pkg::ST_MISS;
        res_slot_q   <= '0;
        res_addr_q   <= '0;
        div_q        <= DIV_W'(cfg_i.bytes) << (SLOT_W - 1);
        quo_q        <= '0;
        step_q       <= STEP_W'(SLOT_W - 1);
      end
      nfbp_pkg::S_PUT_DIV: begin
        // one restoring divide step per cycle, quotient msb first
        if (!borrow) rem_q <= trial[ADDR_W-1:0];
        quo_q  <= {quo_q[SLOT_W-2:0], !borrow};
        div_q  <= div_q >> 1;
        step_q <= step_q - STEP_W'(1);
      end
      nfbp_pkg::S_PUT_CHK: begin
        if (rem_q == '0) begin
          res_status_q <= nfbp_pkg::ST_OK;
          res_slot_q   <= quo_q;
          res_addr_q   <= addr_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/next_fit_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_pool_allocator_unit
// Pool allocator for equal-sized blocks with a next-fit free search.
// ----------------------------------------------------------------------------
// Get: the used map is scanned from the next-fit start, one slot checked per
//   cycle, until a free slot is found or every slot has been tried.
// Put: ten restoring divide steps locate the slot.
// One item at a time; input stalls until the result is handed to the output.
// After reset a clearing pass over all 1024 slots empties the used map; inputs
//   stall meanwhile, configuration writes are taken at any time.
module next_fit_block_pool_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nfbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nfbp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request beat
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [nfbp_pkg::ADDR_W-1:0]         chunk_address_i,
  // result beat
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [nfbp_pkg::SLOT_W-1:0]         slot_index_o,
  output logic [nfbp_pkg::ADDR_W-1:0]         block_address_o
);

  localparam int CNT_W   = nfbp_pkg::CNT_W;
  localparam int BYTES_W = nfbp_pkg::BYTES_W;

  logic [CNT_W-1:0]           block_count_q;
  logic [BYTES_W-1:0]         block_bytes_q;
  logic [nfbp_pkg::BASE_W-1:0] pool_base_q;

  nfbp_pkg::core_cfg_t cfg;
  nfbp_pkg::core_res_t res;
  nfbp_pkg::map_req_t  map_req;
  logic                map_rdata;
  logic                out_free;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [nfbp_pkg::SLOT_W-1:0] slot_q;
  logic [nfbp_pkg::ADDR_W-1:0] addr_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= CNT_W'(nfbp_pkg::MAX_BLOCKS);
      block_bytes_q <= BYTES_W'(1);
      pool_base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        nfbp_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[CNT_W-1:0];
        nfbp_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_data_i[BYTES_W-1:0];
        nfbp_pkg::CFG_POOL_BASE:   pool_base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp count and size into their legal ranges
  always_comb begin
    cfg.count = block_count_q;
    if (block_count_q == '0) cfg.count = CNT_W'(1);
    else if (block_count_q > CNT_W'(nfbp_pkg::MAX_BLOCKS)) begin
      cfg.count = CNT_W'(nfbp_pkg::MAX_BLOCKS);
    end
    cfg.bytes = block_bytes_q;
    if (block_bytes_q == '0) cfg.bytes = BYTES_W'(1);
    else if (block_bytes_q > BYTES_W'(nfbp_pkg::BYTES_MAX)) begin
      cfg.bytes = BYTES_W'(nfbp_pkg::BYTES_MAX);
    end
    cfg.base = pool_base_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  nfbp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .chunk_address_i (chunk_address_i),
    .out_free_i      (out_free),
    .res_o           (res),
    .map_req_o       (map_req),
    .map_rdata_i     (map_rdata)
  );

  nfbp_used_map u_used_map (
    .clk_i   (clk_i),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      slot_q   <= res.slot;
      addr_q   <= res.addr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = slot_q;
  assign block_address_o = addr_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-fit block pool allocator. A behavioral
// copy of the pool (used map, used total, search start, registers) predicts
// every result beat; a scoreboard compares each one field by field. Directed
// tests cover register extremes, a full pool, wrap-around and bad puts. They
// are followed by random phases, each with its own register settings.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS = nfbp_pkg::MAX_BLOCKS;
  localparam int SLOT_W     = nfbp_pkg::SLOT_W;
  localparam int CNT_W      = nfbp_pkg::CNT_W;
  localparam int BYTES_W    = nfbp_pkg::BYTES_W;
  localparam int BYTES_MAX  = nfbp_pkg::BYTES_MAX;
  localparam int BASE_W     = nfbp_pkg::BASE_W;
  localparam int ADDR_W     = nfbp_pkg::ADDR_W;
  localparam int CFG_IDX_W  = nfbp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = nfbp_pkg::CFG_DATA_W;

  localparam int CLK_PERIOD  = 10;
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = MAX_BLOCKS + 16;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 40;
  localparam int PRINT_MAX   = 40;

  // Operation codes and the register index past the last register
  localparam logic FN_GET = 1'b0;
  localparam logic FN_PUT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    nfbp_pkg::status_e status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
  } pool_result_t;

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [ADDR_W-1:0]     chunk_address_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            status_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [ADDR_W-1:0]     block_address_o;

  // Shadow copy of the pool and its registers
  bit                slot_used [MAX_BLOCKS];
  int unsigned       used_total  = 0;
  int unsigned       search_from = 0;
  logic [CNT_W-1:0]  reg_count   = 11'd1024;
  logic [BYTES_W-1:0] reg_bytes  = 17'd1;
  logic [BASE_W-1:0] reg_base    = '0;

  pool_result_t pending_results [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  bit           calm         = 1'b0;

  next_fit_block_pool_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .chunk_address_i (chunk_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .block_address_o (block_address_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register values as the pool sees them, clamped to their legal ranges
  function automatic int unsigned live_count();
    int unsigned c;
    c = reg_count;
    if (c == 0) c = 1;
    if (c > MAX_BLOCKS) c = MAX_BLOCKS;
    return c;
  endfunction

  function automatic longint unsigned live_bytes();
    longint unsigned b;
    b = reg_bytes;
    if (b == 0) b = 1;
    if (b > BYTES_MAX) b = BYTES_MAX;
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_address(input int unsigned s);
    longint unsigned sum;
    longint unsigned b;
    b   = reg_base;
    sum = b + longint'(s) * live_bytes();
    return sum[ADDR_W-1:0];
  endfunction

  // Next-fit get or checked put; updates the shadow pool
  function automatic pool_result_t next_pool_result(input logic f,
                                                    input logic [ADDR_W-1:0] a);
    pool_result_t    r;
    int unsigned     cnt;
    int unsigned     start;
    int unsigned     s;
    bit              found;
    longint unsigned b;
    longint unsigned base;
    longint unsigned off;
    longint unsigned idx;
    cnt    = live_count();
    b      = live_bytes();
    base   = reg_base;
    r.slot = '0;
    r.addr = '0;
    found  = 1'b0;
    if (f == FN_GET) begin
      r.status = nfbp_pkg::ST_FULL;
      if (used_total < cnt) begin
        start = (search_from >= cnt) ? 0 : search_from;
        for (int k = 0; k < cnt; k++) begin
          s = start + k;
          if (s >= cnt) s -= cnt;
          if (!found && !slot_used[s]) begin
            found        = 1'b1;
            slot_used[s] = 1'b1;
            used_total++;
            search_from  = s + 1;
            r.status     = nfbp_pkg::ST_OK;
            r.slot       = s[SLOT_W-1:0];
            r.addr       = slot_address(s);
          end
        end
      end
    end else begin
      r.status = nfbp_pkg::ST_MISS;
      if (a >= base) begin
        off = a - base;
        if (off % b == 0) begin
          idx = off / b;
          if (idx < cnt) begin
            if (slot_used[idx]) begin
              slot_used[idx] = 1'b0;
              if (used_total > 0) used_total--;
            end
            r.status = nfbp_pkg::ST_OK;
            r.slot   = idx[SLOT_W-1:0];
            r.addr   = slot_address(32'(idx));
          end
        end
      end
    end
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Scoreboard: check result beats, track register writes, predict on accept
  always @(posedge clk_i) begin : scoreboard
    pool_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d slot=%0d addr=%h",
                                    status_o, slot_index_o, block_address_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (slot_index_o !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", slot_index_o, want.slot));
          if (block_address_o !== want.addr)
            report_mismatch($sformatf("address %h, want %h", block_address_o, want.addr));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nfbp_pkg::CFG_BLOCK_COUNT: reg_count = cfg_data_i[CNT_W-1:0];
          nfbp_pkg::CFG_BLOCK_BYTES: reg_bytes = cfg_data_i[BYTES_W-1:0];
          nfbp_pkg::CFG_POOL_BASE:   reg_base  = cfg_data_i[BASE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(next_pool_result(func_i, chunk_address_i));
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin : result_stall
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  // One request beat; valid stays high on return so back-to-back beats need
  // no drop
  task automatic send_req(input logic f, input logic [ADDR_W-1:0] a);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    chunk_address_i <= a;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  // Write all registers once the pool is idle, optionally the spare index too
  task automatic set_config(input logic [CFG_DATA_W-1:0] cnt_d,
                            input logic [CFG_DATA_W-1:0] bytes_d,
                            input logic [CFG_DATA_W-1:0] base_d,
                            input bit with_spare);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] word [4];
    int                    n;
    idx[0]  = nfbp_pkg::CFG_BLOCK_COUNT;
    idx[1]  = nfbp_pkg::CFG_BLOCK_BYTES;
    idx[2]  = nfbp_pkg::CFG_POOL_BASE;
    idx[3]  = CFG_SPARE;
    word[0] = cnt_d;
    word[1] = bytes_d;
    word[2] = base_d;
    word[3] = $urandom();
    n       = with_spare ? 4 : 3;
    wait_drained();
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= word[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    // let the shadow registers settle before stimulus reads them
    @(posedge clk_i);
  endtask

  // Reset values: byte addressing from zero, puts that hit and miss
  task automatic test_default_config();
    send_req(FN_GET, '0);
    send_req(FN_GET, '1);
    send_req(FN_GET, '0);
    send_req(FN_PUT, 33'd1);
    send_req(FN_PUT, 33'd1);             // already free
    send_req(FN_PUT, 33'd0);             // zero is an ordinary address
    send_req(FN_PUT, 33'd1024);          // one past the pool
    send_req(FN_PUT, 33'h1_FFFF_FFFF);
  endtask

  // Oversized and zero register values get clamped; masking of write data
  task automatic test_register_extremes();
    set_config('1, '1, '1, 1'b1);
    send_req(FN_GET, '0);
    send_req(FN_PUT, slot_address(3) + 33'd1);      // off a block boundary
    send_req(FN_PUT, {1'b0, reg_base} - 33'd1);     // below the base
    send_req(FN_PUT, slot_address(MAX_BLOCKS - 1));
    send_req(FN_PUT, slot_address(MAX_BLOCKS));
    // count and size fields both read as zero
    set_config(32'h0000_0800, 32'h0002_0000, '0, 1'b0);
    send_req(FN_GET, '0);
    send_req(FN_PUT, '0);
    send_req(FN_GET, '0);
  endtask

  // Small pool: fill it, hit full, free one slot, wrap around to it
  task automatic test_pool_full_wrap();
    set_config(32'd4, 32'd16, 32'h0000_1000, 1'b0);
    repeat (5) send_req(FN_GET, '0);
    send_req(FN_PUT, 33'h1010);
    send_req(FN_GET, '0);
  endtask

  // Random phases: mostly well-formed puts of used slots, some noise
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] cnt_d;
    logic [CFG_DATA_W-1:0] bytes_d;
    logic [CFG_DATA_W-1:0] base_d;
    logic [ADDR_W-1:0]     a;
    int unsigned           get_pct;
    int unsigned           cnt;
    int unsigned           s;
    int unsigned           r;
    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      cnt_d = $urandom_range(1, 16);
      else if (r < 65) cnt_d = $urandom_range(17, 96);
      else if (r < 78) cnt_d = MAX_BLOCKS;
      else if (r < 90) cnt_d = $urandom();
      else             cnt_d = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd2047;
      case ($urandom_range(0, 5))
        0:       bytes_d = 32'd1;
        1:       bytes_d = 32'd1 << $urandom_range(1, 16);
        2:       bytes_d = $urandom_range(1, BYTES_MAX);
        3:       bytes_d = BYTES_MAX;
        4:       bytes_d = $urandom();
        default: bytes_d = 32'd0;
      endcase
      case ($urandom_range(0, 3))
        0:       base_d = '0;
        1:       base_d = '1;
        2:       base_d = $urandom();
        default: base_d = $urandom() & 32'hFFFF_0000;
      endcase
      set_config(cnt_d, bytes_d, base_d, $urandom_range(0, 3) == 0);
      calm    = (p % 6 == 3);
      get_pct = $urandom_range(30, 70);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cnt = live_count();
        if ($urandom_range(0, 99) < get_pct) begin
          send_req(FN_GET, {1'($urandom_range(0, 1)), $urandom()});
        end else begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            s = $urandom_range(0, cnt - 1);
            for (int t = 0; t < 8 && !slot_used[s]; t++) s = $urandom_range(0, cnt - 1);
            a = slot_address(s);
          end else if (r < 78) begin
            a = slot_address($urandom_range(0, cnt - 1));
          end else begin
            case ($urandom_range(0, 4))
              0:       a = {1'($urandom_range(0, 1)), $urandom()};
              1:       a = {1'b0, reg_base} - 33'd1;
              2:       a = slot_address($urandom_range(0, cnt - 1)) + 33'd1;
              3:       a = slot_address(cnt);
              default: a = slot_address($urandom_range(MAX_BLOCKS, 2 * MAX_BLOCKS - 1));
            endcase
          end
          send_req(FN_PUT, a);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    func_i          = FN_GET;
    chunk_address_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_register_extremes();
    test_pool_full_wrap();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
